[hdl/osm_pkg.sv]
// package for the order-statistic multiset core
// holds sizes, status codes and the controller/datapath struct types; no dependencies
`default_nettype none
package osm_pkg;

  // key space and derived widths
  localparam int KEY_SPACE = 65536;
  localparam int ITEM_W    = 17;
  localparam int RANK_W    = 32;
  localparam int CNT_W     = 32;
  localparam int POS_W     = $clog2(KEY_SPACE + 1);
  localparam int ADDR_W    = $clog2(KEY_SPACE);
  localparam int CLR_W     = ADDR_W + 1;

  // largest power of two not above n
  function automatic int top_pow2(input int n);
    int p;
    p = 1;
    while (p * 2 <= n) p = p * 2;
    return p;
  endfunction

  localparam int TOP_STEP = top_pow2(KEY_SPACE);

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TAKE   = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED    = 2'd0,
    ST_TAKEN       = 2'd1,
    ST_NOT_PRESENT = 2'd2,
    ST_REFUSED     = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic    latch;
    logic    clr_wr;
    logic    start_ins;
    logic    start_find;
    logic    fnd_skip;
    logic    fnd_rd;
    logic    fnd_cmp;
    logic    set_found;
    logic    upd_rd;
    logic    upd_wr;
    logic    load_out;
    status_t code;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_take;
    logic key_bad;
    logic total_full;
    logic rank_bad;
    logic step_zero;
    logic next_in;
    logic upd_last;
    logic out_free;
    logic clr_last;
  } dp_stat_t;

endpackage
`default_nettype wire

[hdl/osm_in_if.sv]
// input channel interface: valid/ready plus one request word
// depends on osm_pkg
`default_nettype none
interface osm_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [osm_pkg::ITEM_W-1:0] item_value;
  logic [osm_pkg::RANK_W-1:0] rank;

  modport source (output valid, output operation, output item_value, output rank,
                  input ready);
  modport sink   (input valid, input operation, input item_value, input rank,
                  output ready);
endinterface
`default_nettype wire

[hdl/osm_out_if.sv]
// result channel interface: valid/ready plus one result word
// depends on osm_pkg
`default_nettype none
interface osm_out_if;
  logic                       valid;
  logic                       ready;
  logic [osm_pkg::ITEM_W-1:0] taken_value;
  logic [1:0]                 status;

  modport source (output valid, output taken_value, output status, input ready);
  modport sink   (input valid, input taken_value, input status, output ready);
endinterface
`default_nettype wire

[hdl/order_statistic_multiset_core.sv]
// top level of the order-statistic multiset: fenwick tree of key counts with k-th take
// depends on osm_pkg, osm_in_if, osm_out_if, osm_ctrl, osm_datapath
//
//   channel  | dir | word
//   in_if    | in  | operation, item_value[16:0], rank[31:0]
//   out_if   | out | taken_value[16:0], status[1:0]
//
// one request word at a time; an insert walks L tree levels upward from the key
// (at most 17), a read then a write per level; a take descends over 17 steps, each a
// check, plus a read and compare if the candidate is in range, then walks upward; the
// single memory port does one read or write a cycle; a refused or missing request goes
// straight to S_RESP; after reset a clearing sweep zeroes all 65536 memory entries
// before the first request is taken; a stalled result stays in the output register
// while the next request is accepted; the next result waits until that word is taken
`default_nettype none
module order_statistic_multiset_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  osm_in_if.sink     in_if,
  osm_out_if.source  out_if
);

  osm_pkg::dp_cmd_t  cmd;
  osm_pkg::dp_stat_t stat;
  logic              ready_w;

  assign in_if.ready = ready_w;

  // sequencing
  osm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (ready_w),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and arithmetic
  osm_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_if.operation),
    .in_item_value   (in_if.item_value),
    .in_rank         (in_if.rank),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_taken_value (out_if.taken_value),
    .out_status      (out_if.status)
  );

endmodule
`default_nettype wire

[hdl/osm_datapath.sv]
// datapath: fenwick count memory, descent/update registers, total count, output register
// depends on osm_pkg; driven by osm_ctrl
`default_nettype none
module osm_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_operation,
  input  wire logic [osm_pkg::ITEM_W-1:0] in_item_value,
  input  wire logic [osm_pkg::RANK_W-1:0] in_rank,
  input  wire osm_pkg::dp_cmd_t           cmd,
  output osm_pkg::dp_stat_t               stat,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [osm_pkg::ITEM_W-1:0]      out_taken_value,
  output logic [1:0]                      out_status
);

  localparam int POS_W  = osm_pkg::POS_W;
  localparam int ADDR_W = osm_pkg::ADDR_W;
  localparam int CNT_W  = osm_pkg::CNT_W;

  // count memory, entry i holds tree position i+1
  logic [CNT_W-1:0] mem [osm_pkg::KEY_SPACE];

  logic                       op_r;
  logic [osm_pkg::ITEM_W-1:0] key_r;
  logic [osm_pkg::RANK_W-1:0] want_r;
  logic [POS_W-1:0]           pos_r;
  logic [POS_W-1:0]           step_r;
  logic [POS_W-1:0]           found_r;
  logic [CNT_W-1:0]           total_r;
  logic [osm_pkg::CLR_W-1:0]  clr_cnt_r;
  logic [CNT_W-1:0]           rd_data_r;
  logic                       out_valid_r;
  logic [osm_pkg::ITEM_W-1:0] out_value_r;
  osm_pkg::status_t           out_status_r;

  logic [POS_W:0]     next_pos;
  logic [POS_W-1:0]   low_bit;
  logic [POS_W:0]     up_pos;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;
  logic [CNT_W-1:0]   mem_wdata;
  logic               mem_re;

  // descent candidate and update successor
  assign next_pos = {1'b0, pos_r} + {1'b0, step_r};
  assign low_bit  = pos_r & (~pos_r + 1'b1);
  assign up_pos   = {1'b0, pos_r} + {1'b0, low_bit};

  // status towards the controller
  assign stat.op_take    = (op_r == osm_pkg::OP_TAKE);
  assign stat.key_bad    = (key_r == '0) ||
                           ({1'b0, key_r} > (osm_pkg::ITEM_W+1)'(osm_pkg::KEY_SPACE));
  assign stat.total_full = (total_r == '1);
  assign stat.rank_bad   = (want_r == '0) || (want_r > total_r);
  assign stat.step_zero  = (step_r == '0);
  assign stat.next_in    = (next_pos <= (POS_W+1)'(osm_pkg::KEY_SPACE));
  assign stat.upd_last   = (up_pos > (POS_W+1)'(osm_pkg::KEY_SPACE));
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.clr_last   = (clr_cnt_r == osm_pkg::CLR_W'(osm_pkg::KEY_SPACE - 1));

  // memory port selection
  always_comb begin
    mem_we    = cmd.clr_wr || cmd.upd_wr;
    mem_re    = cmd.upd_rd || cmd.fnd_rd;
    mem_wdata = '0;
    if (cmd.upd_wr) begin
      mem_wdata = stat.op_take ? rd_data_r - 1'b1 : rd_data_r + 1'b1;
    end
    if (cmd.clr_wr) begin
      mem_addr = clr_cnt_r[ADDR_W-1:0];
    end else if (cmd.fnd_rd) begin
      mem_addr = ADDR_W'(next_pos - 1'b1);
    end else begin
      mem_addr = ADDR_W'(pos_r - 1'b1);
    end
  end

  // single-port count memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // request word and walk registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_operation;
      key_r  <= in_item_value;
      want_r <= in_rank;
    end
    if (cmd.start_ins) begin
      pos_r <= POS_W'(key_r);
    end else if (cmd.start_find) begin
      pos_r  <= '0;
      step_r <= POS_W'(osm_pkg::TOP_STEP);
    end else if (cmd.fnd_skip) begin
      step_r <= step_r >> 1;
    end else if (cmd.fnd_cmp) begin
      if (rd_data_r < want_r) begin
        pos_r  <= next_pos[POS_W-1:0];
        want_r <= want_r - rd_data_r;
      end
      step_r <= step_r >> 1;
    end else if (cmd.set_found) begin
      pos_r   <= pos_r + 1'b1;
      found_r <= pos_r + 1'b1;
    end else if (cmd.upd_wr) begin
      pos_r <= up_pos[POS_W-1:0];
    end
  end

  // clear sweep counter and stored copy count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      total_r   <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.load_out && cmd.code == osm_pkg::ST_INSERTED) begin
        total_r <= total_r + 1'b1;
      end else if (cmd.load_out && cmd.code == osm_pkg::ST_TAKEN) begin
        total_r <= total_r - 1'b1;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= cmd.code;
      out_value_r  <= (cmd.code == osm_pkg::ST_TAKEN) ? osm_pkg::ITEM_W'(found_r) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_taken_value = out_value_r;
  assign out_status      = out_status_r;

  // a result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over pending word");

  // the found key lies inside the key space
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_found |=> (found_r >= POS_W'(1) &&
                       found_r <= POS_W'(osm_pkg::KEY_SPACE)))
    else $error("found key out of range");

  // a successful take removes exactly one copy
  a_take_total: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && cmd.code == osm_pkg::ST_TAKEN) |=> total_r == $past(total_r) - 1'b1)
    else $error("take did not decrement total");

  // refused and missing requests leave the total alone
  a_noop_total: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && (cmd.code == osm_pkg::ST_REFUSED ||
                      cmd.code == osm_pkg::ST_NOT_PRESENT)) |=> $stable(total_r))
    else $error("total changed on a refused request");

endmodule
`default_nettype wire

[hdl/osm_ctrl.sv]
// controller: clearing sweep, request decode, fenwick descent and update sequencing
// depends on osm_pkg; drives osm_datapath
`default_nettype none
module osm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire osm_pkg::dp_stat_t stat,
  output osm_pkg::dp_cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_DECODE  = 9'b000000100,
    S_FND_CHK = 9'b000001000,
    S_FND_CMP = 9'b000010000,
    S_UPD_RD  = 9'b000100000,
    S_UPD_WR  = 9'b001000000,
    S_RESP    = 9'b010000000,
    S_SPARE   = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  osm_pkg::status_t code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      code_r  <= osm_pkg::ST_INSERTED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.code  = code_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (!stat.op_take) begin
          if (stat.key_bad || stat.total_full) begin
            code_nxt  = osm_pkg::ST_REFUSED;
            state_nxt = S_RESP;
          end else begin
            cmd.start_ins = 1'b1;
            state_nxt     = S_UPD_RD;
          end
        end else if (stat.rank_bad) begin
          code_nxt  = osm_pkg::ST_NOT_PRESENT;
          state_nxt = S_RESP;
        end else begin
          cmd.start_find = 1'b1;
          state_nxt      = S_FND_CHK;
        end
      end
      S_FND_CHK: begin
        priority if (stat.step_zero) begin
          cmd.set_found = 1'b1;
          state_nxt     = S_UPD_RD;
        end else if (stat.next_in) begin
          cmd.fnd_rd = 1'b1;
          state_nxt  = S_FND_CMP;
        end else begin
          cmd.fnd_skip = 1'b1;
        end
      end
      S_FND_CMP: begin
        cmd.fnd_cmp = 1'b1;
        state_nxt   = S_FND_CHK;
      end
      S_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_nxt  = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        if (stat.upd_last) begin
          code_nxt  = stat.op_take ? osm_pkg::ST_TAKEN : osm_pkg::ST_INSERTED;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_UPD_RD;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // no request is taken during the clearing sweep
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("request accepted while clearing");

  // an accepted request is decoded on the next cycle
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted request not decoded");

  // memory is never read and written in the same cycle
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !((cmd.upd_rd || cmd.fnd_rd) && (cmd.upd_wr || cmd.clr_wr)))
    else $error("memory port used twice");

endmodule
`default_nettype wire

[verif/tb_top.sv]
// testbench for order_statistic_multiset_core: directed table plus random insert/take traffic
// predicts every result word with its own fenwick tree; depends on osm_pkg, osm_in_if, osm_out_if
module tb_top;
  import osm_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int unsigned FIELD_MAX   = (1 << ITEM_W) - 1;
  localparam int          DRAIN_WAIT  = 100;

  // expected result word
  typedef struct packed {
    logic [ITEM_W-1:0] value;
    status_t           status;
  } result_word_t;

  // one row of the directed table
  typedef struct packed {
    logic              op;
    logic [ITEM_W-1:0] key;
    logic [RANK_W-1:0] rank;
    bit                typed;
    logic [ITEM_W-1:0] exp_value;
    status_t           exp_status;
  } stim_row_t;

  logic clk;
  logic rst_n;

  osm_in_if  in_ch ();
  osm_out_if out_ch ();

  order_statistic_multiset_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // predictor state: fenwick partial sums and number of stored copies
  logic [CNT_W-1:0] fen_counts [1:KEY_SPACE];
  logic [CNT_W-1:0] stored_total;

  result_word_t pending_results [$];
  result_word_t oldest_result;
  int           error_count;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  bit           filling;
  int unsigned  fill_limit;

  // empty multiset, bad keys, bad ranks, extreme keys, duplicates, largest and smallest rank
  stim_row_t directed_rows [23] = '{
    '{OP_TAKE,   17'd0,      32'd1,          1'b1, 17'd0,     ST_NOT_PRESENT},
    '{OP_TAKE,   17'd131071, 32'hFFFF_FFFF,  1'b1, 17'd0,     ST_NOT_PRESENT},
    '{OP_TAKE,   17'd0,      32'd0,          1'b1, 17'd0,     ST_NOT_PRESENT},
    '{OP_INSERT, 17'd0,      32'd0,          1'b1, 17'd0,     ST_REFUSED},
    '{OP_INSERT, 17'd65537,  32'd0,          1'b1, 17'd0,     ST_REFUSED},
    '{OP_INSERT, 17'd131071, 32'hFFFF_FFFF,  1'b1, 17'd0,     ST_REFUSED},
    '{OP_INSERT, 17'd1,      32'd0,          1'b1, 17'd0,     ST_INSERTED},
    '{OP_INSERT, 17'd65536,  32'd0,          1'b1, 17'd0,     ST_INSERTED},
    '{OP_INSERT, 17'd65535,  32'hFFFF_FFFF,  1'b1, 17'd0,     ST_INSERTED},
    '{OP_INSERT, 17'd1,      32'd0,          1'b1, 17'd0,     ST_INSERTED},
    '{OP_INSERT, 17'd32768,  32'd0,          1'b1, 17'd0,     ST_INSERTED},
    '{OP_INSERT, 17'd43690,  32'd0,          1'b1, 17'd0,     ST_INSERTED},
    '{OP_INSERT, 17'd21845,  32'd0,          1'b1, 17'd0,     ST_INSERTED},
    '{OP_TAKE,   17'd0,      32'd8,          1'b1, 17'd0,     ST_NOT_PRESENT},
    '{OP_TAKE,   17'd0,      32'd0,          1'b1, 17'd0,     ST_NOT_PRESENT},
    '{OP_TAKE,   17'd131071, 32'd7,          1'b1, 17'd65536, ST_TAKEN},
    '{OP_TAKE,   17'd0,      32'd1,          1'b1, 17'd1,     ST_TAKEN},
    '{OP_TAKE,   17'd0,      32'd1,          1'b1, 17'd1,     ST_TAKEN},
    '{OP_TAKE,   17'd0,      32'd3,          1'b0, 17'd0,     ST_TAKEN},
    '{OP_TAKE,   17'd0,      32'd2,          1'b0, 17'd0,     ST_TAKEN},
    '{OP_TAKE,   17'd0,      32'd2,          1'b0, 17'd0,     ST_TAKEN},
    '{OP_TAKE,   17'd0,      32'd1,          1'b0, 17'd0,     ST_TAKEN},
    '{OP_TAKE,   17'd0,      32'd1,          1'b1, 17'd0,     ST_NOT_PRESENT}
  };

  // add or remove one copy along the upward fenwick path
  function automatic void fen_walk_up(int unsigned pos, bit add);
    while (pos >= 1 && pos <= KEY_SPACE) begin
      if (add) begin
        fen_counts[pos] += 1;
      end else begin
        fen_counts[pos] -= 1;
      end
      pos += pos & (~pos + 1);
    end
  endfunction

  // apply one request word to the predictor and return the result word it gives
  function automatic result_word_t predict_word(logic op, logic [ITEM_W-1:0] key,
                                                logic [RANK_W-1:0] want);
    result_word_t      res;
    int unsigned       step_sz;
    int unsigned       pos;
    int unsigned       nxt;
    logic [RANK_W-1:0] left;
    res.value = '0;
    if (op == OP_INSERT) begin
      if (key == 0 || key > KEY_SPACE || stored_total == '1) begin
        res.status = ST_REFUSED;
      end else begin
        fen_walk_up(key, 1'b1);
        stored_total += 1;
        res.status = ST_INSERTED;
      end
      return res;
    end
    if (want == 0 || want > stored_total) begin
      res.status = ST_NOT_PRESENT;
      return res;
    end
    // descent: largest position whose prefix sum is below the rank
    step_sz = 1;
    while (step_sz * 2 <= KEY_SPACE) step_sz *= 2;
    pos  = 0;
    left = want;
    while (step_sz != 0) begin
      nxt = pos + step_sz;
      if (nxt <= KEY_SPACE && fen_counts[nxt] < left) begin
        pos  = nxt;
        left -= fen_counts[nxt];
      end
      step_sz >>= 1;
    end
    fen_walk_up(pos + 1, 1'b0);
    stored_total -= 1;
    res.value  = ITEM_W'(pos + 1);
    res.status = ST_TAKEN;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // present one word, entered and left at a falling edge; expectation queued on acceptance
  task automatic send_word(logic op, logic [ITEM_W-1:0] key, logic [RANK_W-1:0] rank,
                           bit typed, result_word_t typed_res);
    result_word_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.operation  = op;
    in_ch.item_value = key;
    in_ch.rank       = rank;
    do @(posedge clk); while (!in_ch.ready);
    res = predict_word(op, key, rank);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // hold the sender until every expected word has come back
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // random traffic: grow to a random size, then drain to empty, with some bad words
  task automatic run_random(int count);
    logic              op;
    logic [ITEM_W-1:0] key;
    logic [RANK_W-1:0] rank;
    int unsigned       pick;
    result_word_t      none;
    none = '0;
    for (int i = 0; i < count; i++) begin
      if (stored_total == 0) begin
        filling = 1'b1;
      end else if (stored_total >= fill_limit) begin
        filling    = 1'b0;
        fill_limit = $urandom_range(4, 150);
      end
      pick = $urandom_range(0, 99);
      op   = (filling == (pick < 75)) ? OP_INSERT : OP_TAKE;
      pick = $urandom_range(0, 99);
      if (op == OP_INSERT) begin
        rank = $urandom;
        if (pick < 3) begin
          key = '0;
        end else if (pick < 8) begin
          key = ITEM_W'($urandom_range(KEY_SPACE + 1, FIELD_MAX));
        end else if (pick < 45) begin
          key = ITEM_W'($urandom_range(1, 48));
        end else if (pick < 50) begin
          key = pick[0] ? ITEM_W'(1) : ITEM_W'(KEY_SPACE);
        end else begin
          key = ITEM_W'($urandom_range(1, KEY_SPACE));
        end
      end else begin
        key = ITEM_W'($urandom_range(0, FIELD_MAX));
        if (stored_total != 0 && pick < 85) begin
          rank = $urandom_range(1, stored_total);
        end else if (pick < 90) begin
          rank = '0;
        end else if (pick < 95) begin
          rank = stored_total + 1;
        end else begin
          rank = $urandom;
        end
      end
      send_word(op, key, rank, 1'b0, none);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, taken_value", out_ch.taken_value, 0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_ch.taken_value !== oldest_result.value) begin
          report_mismatch("taken_value", out_ch.taken_value, oldest_result.value);
        end
        if (out_ch.status !== oldest_result.status) begin
          report_mismatch("status", out_ch.status, oldest_result.status);
        end
      end
    end
  end

  // main sequence
  initial begin
    int           idle_by_phase  [4];
    int           stall_by_phase [4];
    result_word_t typed_res;
    idle_by_phase  = '{0, 79, 0, 29};
    stall_by_phase = '{0, 0, 79, 29};
    error_count    = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    filling        = 1'b1;
    fill_limit     = 40;
    stored_total   = '0;
    for (int i = 1; i <= KEY_SPACE; i++) fen_counts[i] = '0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_INSERT;
    in_ch.item_value = '0;
    in_ch.rank       = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      typed_res.value  = directed_rows[i].exp_value;
      typed_res.status = directed_rows[i].exp_status;
      send_word(directed_rows[i].op, directed_rows[i].key, directed_rows[i].rank,
                directed_rows[i].typed, typed_res);
    end
    wait_drained();

    // random traffic under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      run_random(325);
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
hdl/osm_pkg.sv
hdl/osm_in_if.sv
hdl/osm_out_if.sv
hdl/osm_datapath.sv
hdl/osm_ctrl.sv
hdl/order_statistic_multiset_core.sv
verif/tb_top.sv
